>>> hdl/sha_pkg.sv
package sha_pkg;

   localparam logic [31:0] K0 = 32'h5A827999;
   localparam logic [31:0] K1 = 32'h6ED9EBA1;
   localparam logic [31:0] K2 = 32'h8F1BBCDC;
   localparam logic [31:0] K3 = 32'hCA62C1D6;
   localparam logic [7:0]  PAD_BYTE = 8'h80;

   localparam logic [31:0] H0_INIT = 32'h67452301;
   localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
   localparam logic [31:0] H2_INIT = 32'h98BADCFE;
   localparam logic [31:0] H3_INIT = 32'h10325476;
   localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

   localparam int BLOCK_BITS = 512;

   // one 64-byte block for the compression core
   typedef struct packed {
      logic [BLOCK_BITS-1:0] blk;
      logic                  last;
   } job_type;

   // job queue status
   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

endpackage

>>> hdl/sha1_hash_engine_unit.sv
// channel   | ports                                             | direction
// request   | req_push, req_full, req_message_byte,             | in
//           | req_byte_present, req_final_item                  |
// response  | rsp_pop, rsp_empty, rsp_digest_word0..4           | out
//
// the front takes one request per cycle while req_full is low and shifts it
// into a 64-byte block; each block goes through a load step, 80 rounds and
// an add step in the round core; a 2-job queue lets the front fill later blocks
// the final request starts padding, one byte per cycle unless a full queue holds it
// reset clears all control state and loads the initial chaining words
// req_full is high while padding or with the job queue full; a waiting digest
// holds a final block back but not the collection of the next message
module sha1_hash_engine_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_message_byte,
   input  logic        req_byte_present,
   input  logic        req_final_item,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_digest_word0,
   output logic [31:0] rsp_digest_word1,
   output logic [31:0] rsp_digest_word2,
   output logic [31:0] rsp_digest_word3,
   output logic [31:0] rsp_digest_word4
);

   sha_pkg::job_type       wr_job, rd_job;
   sha_pkg::fifo_stat_type q_stat;
   logic                   q_push, q_pop;

   // byte collection and padding
   sha_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_message_byte (req_message_byte),
      .req_byte_present (req_byte_present),
      .req_final_item   (req_final_item),
      .q_stat           (q_stat),
      .q_push           (q_push),
      .q_job            (wr_job)
   );

   // block queue
   sha_job_fifo u_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wr_job (wr_job),
      .pop    (q_pop),
      .rd_job (rd_job),
      .stat   (q_stat)
   );

   // compression
   sha_round_core u_core (
      .clock            (clock),
      .reset            (reset),
      .q_job            (rd_job),
      .q_stat           (q_stat),
      .q_pop            (q_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_digest_word0 (rsp_digest_word0),
      .rsp_digest_word1 (rsp_digest_word1),
      .rsp_digest_word2 (rsp_digest_word2),
      .rsp_digest_word3 (rsp_digest_word3),
      .rsp_digest_word4 (rsp_digest_word4)
   );

   // queue never overflows or underflows
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full) else $error("job queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty) else $error("job queue underflow");

   // a held digest is not overwritten before it is taken
   a_digest_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> $stable(rsp_digest_word0) && !rsp_empty)
      else $error("digest changed while waiting");

endmodule

>>> hdl/sha_job_fifo.sv
module sha_job_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  sha_pkg::job_type       wr_job,
   input  logic                   pop,
   output sha_pkg::job_type       rd_job,
   output sha_pkg::fifo_stat_type stat
);

   sha_pkg::job_type mem [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= wr_job;
      end
   end

   assign rd_job     = mem[rd_ptr_ff];
   assign stat.full  = (count_ff == 2'd2);
   assign stat.empty = (count_ff == 2'd0);

endmodule

>>> hdl/sha_front.sv
module sha_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [7:0]             req_message_byte,
   input  logic                   req_byte_present,
   input  logic                   req_final_item,
   input  sha_pkg::fifo_stat_type q_stat,
   output logic                   q_push,
   output sha_pkg::job_type       q_job
);

   typedef enum logic {ST_COLLECT, ST_PAD} state_type;

   state_type  state_ff, state_in;
   logic [sha_pkg::BLOCK_BITS-1:0] blk_ff, blk_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] total_ff, total_in;
   logic [63:0] len_ff, len_in;
   logic        first_ff, first_in;
   logic        ovf_ff, ovf_in;

   logic        accept;
   logic        shift_en;
   logic [7:0]  shift_byte;
   logic        blk_done;
   logic [2:0]  lsel;
   logic [5:0]  new_cnt;
   logic [63:0] new_total;

   assign req_full = (state_ff != ST_COLLECT) || q_stat.full;
   assign accept   = req_push && !req_full;
   assign lsel     = ~cnt_ff[2:0];

   // byte selection and padding sequence
   always_comb begin
      state_in   = state_ff;
      total_in   = total_ff;
      len_in     = len_ff;
      first_in   = first_ff;
      ovf_in     = ovf_ff;
      shift_en   = 1'b0;
      shift_byte = req_message_byte;
      q_push     = 1'b0;
      q_job.last = 1'b0;
      new_cnt    = req_byte_present ? cnt_ff + 6'd1 : cnt_ff;
      new_total  = total_ff;
      case (state_ff)
         ST_COLLECT: begin
            if (accept && req_byte_present) begin
               shift_en = 1'b1;
               if (cnt_ff == 6'd63) begin
                  new_total = total_ff + 64'd512;
               end
            end
            total_in = new_total;
            if (accept && req_final_item) begin
               state_in = ST_PAD;
               first_in = 1'b1;
               ovf_in   = 1'b0;
               len_in   = new_total + {55'd0, new_cnt, 3'b000};
            end
         end
         ST_PAD: begin
            if (!(cnt_ff == 6'd63 && q_stat.full)) begin
               shift_en = 1'b1;
            end
            if (first_ff) begin
               shift_byte = sha_pkg::PAD_BYTE;
            end else if (cnt_ff >= 6'd56 && !ovf_ff) begin
               shift_byte = len_ff[{lsel, 3'b000} +: 8];
            end else begin
               shift_byte = 8'h00;
            end
            if (shift_en) begin
               first_in = 1'b0;
               if (first_ff) begin
                  ovf_in = (cnt_ff >= 6'd56) && (cnt_ff != 6'd63);
               end
               if (cnt_ff == 6'd63) begin
                  ovf_in     = 1'b0;
                  q_job.last = !first_ff && !ovf_ff;
                  if (!first_ff && !ovf_ff) begin
                     state_in = ST_COLLECT;
                     total_in = 64'd0;
                  end
               end
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
      blk_done  = shift_en && (cnt_ff == 6'd63);
      q_push    = blk_done;
      blk_in    = shift_en ? {blk_ff[sha_pkg::BLOCK_BITS-9:0], shift_byte} : blk_ff;
      cnt_in    = shift_en ? cnt_ff + 6'd1 : cnt_ff;
      q_job.blk = blk_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
         cnt_ff   <= 6'd0;
         total_ff <= 64'd0;
         first_ff <= 1'b0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         total_ff <= total_in;
         first_ff <= first_in;
         ovf_ff   <= ovf_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      len_ff <= len_in;
   end

endmodule

>>> hdl/sha_round_core.sv
module sha_round_core (
   input  logic                   clock,
   input  logic                   reset,
   input  sha_pkg::job_type       q_job,
   input  sha_pkg::fifo_stat_type q_stat,
   output logic                   q_pop,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [31:0]            rsp_digest_word0,
   output logic [31:0]            rsp_digest_word1,
   output logic [31:0]            rsp_digest_word2,
   output logic [31:0]            rsp_digest_word3,
   output logic [31:0]            rsp_digest_word4
);

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_ADD} state_type;

   state_type  state_ff, state_in;
   logic [6:0] round_ff, round_in;
   logic       last_ff, last_in;
   logic       res_ff, res_in;
   logic [sha_pkg::BLOCK_BITS-1:0] win_ff, win_in;
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0] a_in, b_in, c_in, d_in, e_in;
   logic [31:0] h0_ff, h1_ff, h2_ff, h3_ff, h4_ff;
   logic [31:0] h0_in, h1_in, h2_in, h3_in, h4_in;
   logic [31:0] r0_ff, r1_ff, r2_ff, r3_ff, r4_ff;
   logic [31:0] r0_in, r1_in, r2_in, r3_in, r4_in;

   logic [31:0] f, k, t, wx, w_new;

   // round function for the current round
   always_comb begin
      if (round_ff < 7'd20) begin
         f = (b_ff & c_ff) | (~b_ff & d_ff);
         k = sha_pkg::K0;
      end else if (round_ff < 7'd40) begin
         f = b_ff ^ c_ff ^ d_ff;
         k = sha_pkg::K1;
      end else if (round_ff < 7'd60) begin
         f = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k = sha_pkg::K2;
      end else begin
         f = b_ff ^ c_ff ^ d_ff;
         k = sha_pkg::K3;
      end
      t = {a_ff[26:0], a_ff[31:27]} + f + e_ff + k + win_ff[511:480];
      // schedule word r+16 from window words 13, 8, 2 and 0
      wx = win_ff[95:64] ^ win_ff[255:224] ^ win_ff[447:416] ^ win_ff[511:480];
      w_new = {wx[30:0], wx[31]};
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      last_in  = last_ff;
      res_in   = res_ff && !rsp_pop;
      win_in   = win_ff;
      {a_in, b_in, c_in, d_in, e_in} = {a_ff, b_ff, c_ff, d_ff, e_ff};
      {h0_in, h1_in, h2_in, h3_in, h4_in} = {h0_ff, h1_ff, h2_ff, h3_ff, h4_ff};
      {r0_in, r1_in, r2_in, r3_in, r4_in} = {r0_ff, r1_ff, r2_ff, r3_ff, r4_ff};
      q_pop = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty && (!q_job.last || !res_ff)) begin
               q_pop    = 1'b1;
               state_in = ST_RUN;
               round_in = 7'd0;
               last_in  = q_job.last;
               win_in   = q_job.blk;
               {a_in, b_in, c_in, d_in, e_in} = {h0_ff, h1_ff, h2_ff, h3_ff, h4_ff};
            end
         end
         ST_RUN: begin
            a_in   = t;
            b_in   = a_ff;
            c_in   = {b_ff[1:0], b_ff[31:2]};
            d_in   = c_ff;
            e_in   = d_ff;
            win_in = {win_ff[479:0], w_new};
            round_in = round_ff + 7'd1;
            if (round_ff == 7'd79) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            state_in = ST_IDLE;
            if (last_ff) begin
               r0_in  = h0_ff + a_ff;
               r1_in  = h1_ff + b_ff;
               r2_in  = h2_ff + c_ff;
               r3_in  = h3_ff + d_ff;
               r4_in  = h4_ff + e_ff;
               res_in = 1'b1;
               h0_in  = sha_pkg::H0_INIT;
               h1_in  = sha_pkg::H1_INIT;
               h2_in  = sha_pkg::H2_INIT;
               h3_in  = sha_pkg::H3_INIT;
               h4_in  = sha_pkg::H4_INIT;
            end else begin
               h0_in = h0_ff + a_ff;
               h1_in = h1_ff + b_ff;
               h2_in = h2_ff + c_ff;
               h3_in = h3_ff + d_ff;
               h4_in = h4_ff + e_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         round_ff <= 7'd0;
         last_ff  <= 1'b0;
         res_ff   <= 1'b0;
         h0_ff    <= sha_pkg::H0_INIT;
         h1_ff    <= sha_pkg::H1_INIT;
         h2_ff    <= sha_pkg::H2_INIT;
         h3_ff    <= sha_pkg::H3_INIT;
         h4_ff    <= sha_pkg::H4_INIT;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
         last_ff  <= last_in;
         res_ff   <= res_in;
         h0_ff    <= h0_in;
         h1_ff    <= h1_in;
         h2_ff    <= h2_in;
         h3_ff    <= h3_in;
         h4_ff    <= h4_in;
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      win_ff <= win_in;
      {a_ff, b_ff, c_ff, d_ff, e_ff} <= {a_in, b_in, c_in, d_in, e_in};
      {r0_ff, r1_ff, r2_ff, r3_ff, r4_ff} <= {r0_in, r1_in, r2_in, r3_in, r4_in};
   end

   assign rsp_empty        = !res_ff;
   assign rsp_digest_word0 = r0_ff;
   assign rsp_digest_word1 = r1_ff;
   assign rsp_digest_word2 = r2_ff;
   assign rsp_digest_word3 = r3_ff;
   assign rsp_digest_word4 = r4_ff;

endmodule
